// File: rtl/core/ctks_pkg.sv
// ----------------------------------------------------------------------------
// ctks_pkg: shared types and constants of the cosine top-k search unit
// Table sizing, datapath widths, register indexes, op codes and the
// control structs passed between the sequencer and its helper units.
// ----------------------------------------------------------------------------
package ctks_pkg;

	// table sizing
	localparam int VOCAB_MAX = 1024;
	localparam int DIM_MAX   = 64;
	localparam int K_MAX     = 16;

	localparam int ROW_W  = $clog2(VOCAB_MAX);
	localparam int COL_W  = $clog2(DIM_MAX);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int KIDX_W = $clog2(K_MAX);
	localparam int KCNT_W = $clog2(K_MAX + 1);

	// element and arithmetic widths
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 2 * ELEM_W;
	localparam int ACC_W   = PROD_W + COL_W;
	localparam int SUM_W   = 37;
	localparam int SQIN_W  = SUM_W + 16;
	localparam int ROOT_W  = (SQIN_W + 1) / 2;
	localparam int QUO_W   = 16;
	localparam int NUM_W   = ELEM_W + 22;
	localparam int DSH_W   = ROOT_W + QUO_W;
	localparam int STEP_W  = 5;
	localparam int SCORE_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int TOPK_W     = 5;
	localparam int VDIM_W     = 7;
	localparam int VCNT_W     = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_TOP_K       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_DIM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOCAB_COUNT = 2'd2;

	localparam logic [TOPK_W-1:0] TOP_K_RST       = 5'd10;
	localparam logic [VDIM_W-1:0] VECTOR_DIM_RST  = 7'd64;
	localparam logic [VCNT_W-1:0] VOCAB_COUNT_RST = 11'd1024;

	// op codes of an input item
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// result status codes
	localparam logic ST_FOUND     = 1'b0;
	localparam logic ST_NOT_FOUND = 1'b1;

	// sqrt / divide unit commands
	typedef struct packed {
		logic start_sqrt;
		logic start_div;
	} sd_cmd_t;

	// best list commands
	typedef struct packed {
		logic clear;
		logic offer;
	} bl_cmd_t;

endpackage

// File: rtl/core/ctks_ram.sv
// ----------------------------------------------------------------------------
// ctks_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ctks_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/ctks_sqdiv.sv
// ----------------------------------------------------------------------------
// ctks_sqdiv: iterative square root and divider
// Integer square root of sum * 2^16, two bits per cycle, then one quotient
// bit per cycle of round(|v| * 2^22 / root) for each row element.
// ----------------------------------------------------------------------------
module ctks_sqdiv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctks_pkg::sd_cmd_t            cmd,
	input  logic [ctks_pkg::SUM_W-1:0]   sum,
	input  logic [ctks_pkg::ELEM_W-1:0]  mag,
	output logic                         busy,
	output logic [ctks_pkg::QUO_W-1:0]   quotient
);
	import ctks_pkg::*;

	typedef enum logic [1:0] {
		SD_IDLE,
		SD_SQRT,
		SD_DIV
	} sd_state_t;

	sd_state_t          state_q;
	logic [STEP_W-1:0]  step_q;
	logic [SQIN_W-1:0]  x_q;
	logic [SQIN_W-1:0]  res_q;
	logic [NUM_W-1:0]   num_q;
	logic [QUO_W-1:0]   quo_q;

	logic [SQIN_W-1:0]  bit_w;
	logic [SQIN_W-1:0]  trial;
	logic [ROOT_W-1:0]  root;
	logic [DSH_W-1:0]   dsh;
	logic [DSH_W-1:0]   num_ext;

	// sqrt trial value for this digit
	assign bit_w   = SQIN_W'(1) << {step_q, 1'b0};
	assign trial   = res_q + bit_w;
	assign root    = res_q[ROOT_W-1:0];
	// shifted divisor for this quotient bit
	assign dsh     = DSH_W'(root) << step_q;
	assign num_ext = DSH_W'(num_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SD_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				SD_IDLE: begin
					if (cmd.start_sqrt) begin
						x_q     <= {sum, 16'd0};
						res_q   <= '0;
						step_q  <= STEP_W'(ROOT_W - 1);
						state_q <= SD_SQRT;
					end else if (cmd.start_div) begin
						num_q   <= (NUM_W'(mag) << 22) + NUM_W'(root[ROOT_W-1:1]);
						quo_q   <= '0;
						step_q  <= STEP_W'(QUO_W - 1);
						state_q <= SD_DIV;
					end
				end
				SD_SQRT: begin
					if (x_q >= trial) begin
						x_q   <= x_q - trial;
						res_q <= (res_q >> 1) + bit_w;
					end else begin
						res_q <= res_q >> 1;
					end
					if (step_q == '0) begin
						state_q <= SD_IDLE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				SD_DIV: begin
					if (num_ext >= dsh) begin
						num_q <= num_q - dsh[NUM_W-1:0];
						quo_q <= quo_q | (QUO_W'(1) << step_q);
					end
					if (step_q == '0) begin
						state_q <= SD_IDLE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				default: begin
					state_q <= SD_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != SD_IDLE);
	assign quotient = quo_q;

endmodule

// File: rtl/core/ctks_best_list.sv
// ----------------------------------------------------------------------------
// ctks_best_list: sorted list of the best scores of one query
// Keeps up to k (score, row) pairs in descending order; an offered score
// goes ahead of equal scores already held.
// ----------------------------------------------------------------------------
module ctks_best_list (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ctks_pkg::bl_cmd_t                  cmd,
	input  logic [ctks_pkg::KCNT_W-1:0]        k,
	input  logic signed [ctks_pkg::SCORE_W-1:0] score,
	input  logic [ctks_pkg::ROW_W-1:0]         index,
	input  logic [ctks_pkg::KIDX_W-1:0]        rd_sel,
	output logic [ctks_pkg::KCNT_W-1:0]        count,
	output logic signed [ctks_pkg::SCORE_W-1:0] rd_score,
	output logic [ctks_pkg::ROW_W-1:0]         rd_index
);
	import ctks_pkg::*;

	logic signed [SCORE_W-1:0] score_q [K_MAX];
	logic [ROW_W-1:0]          index_q [K_MAX];
	logic [KCNT_W-1:0]         count_q;
	logic [K_MAX-1:0]          ge;

	// entries at and after the insert point
	always_comb begin
		for (int i = 0; i < K_MAX; i++) begin
			ge[i] = (KCNT_W'(i) >= count_q) || (score >= score_q[i]);
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.offer && (count_q < k)) begin
			count_q <= count_q + KCNT_W'(1);
		end
	end

	// insert and shift down
	for (genvar gi = 0; gi < K_MAX; gi++) begin : g_entry
		if (gi == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (cmd.offer && ge[gi]) begin
					score_q[gi] <= score;
					index_q[gi] <= index;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (cmd.offer && ge[gi]) begin
					if (!ge[gi-1]) begin
						score_q[gi] <= score;
						index_q[gi] <= index;
					end else begin
						score_q[gi] <= score_q[gi-1];
						index_q[gi] <= index_q[gi-1];
					end
				end
			end
		end
	end

	assign count    = count_q;
	assign rd_score = score_q[rd_sel];
	assign rd_index = index_q[rd_sel];

endmodule

// File: rtl/core/cosine_top_k_neighbour_search_unit.sv
// Cosine top-k neighbour search. A load item writes one Q4.12 element; an
// element in the last column of its row also normalises the row to Q1.14
// through the sum of squares on the shared multiplier, the two-bit-per-cycle
// square root and the one-bit-per-cycle divider. A query copies the query
// row, reads the loaded flag of every table row, runs the multiply-accumulate
// and the list insert for each other loaded row, then hands out one result
// per cycle while the output is not stalled. After reset the block sweeps its
// loaded flags and takes no item until that pass is done.
// ----------------------------------------------------------------------------
// cosine_top_k_neighbour_search_unit: top level and sequencer
// Embedding table, query row and loaded flags in memories; one multiplier
// shared by normalisation and scoring, one sqrt/divide unit, one best list.
// ----------------------------------------------------------------------------
module cosine_top_k_neighbour_search_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ctks_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ctks_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  op,
	input  logic [ctks_pkg::ROW_W-1:0]            row_index,
	input  logic [ctks_pkg::COL_W-1:0]            column_index,
	input  logic signed [ctks_pkg::ELEM_W-1:0]    element_value,
	input  logic [ctks_pkg::ROW_W-1:0]            query_row,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [ctks_pkg::ROW_W-1:0]            neighbour_index,
	output logic signed [ctks_pkg::SCORE_W-1:0]   similarity,
	output logic                                  status,
	output logic                                  last
);
	import ctks_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_N_SUM_A,
		ST_N_SUM_D,
		ST_N_SUM_ACC,
		ST_N_ROOT,
		ST_N_ROOT_W,
		ST_N_ZERO,
		ST_N_DIV_A,
		ST_N_DIV_D,
		ST_N_DIV_W,
		ST_N_MARK,
		ST_Q_FLAG,
		ST_Q_CPY_A,
		ST_Q_CPY_D,
		ST_Q_ROW_A,
		ST_Q_ROW_D,
		ST_Q_DOT_A,
		ST_Q_DOT_D,
		ST_Q_DOT_ACC,
		ST_Q_OFFER,
		ST_Q_NEXT,
		ST_EMIT,
		ST_EMIT_NF
	} state_t;

	state_t                   state_q;
	logic [TOPK_W-1:0]        top_k_q;
	logic [VDIM_W-1:0]        vector_dim_q;
	logic [VCNT_W-1:0]        vocab_count_q;
	logic [ROW_W-1:0]         row_q;
	logic [ROW_W-1:0]         r_q;
	logic [ROW_W-1:0]         qrow_q;
	logic [COL_W-1:0]         j_q;
	logic [KCNT_W-1:0]        k_q;
	logic [KIDX_W-1:0]        e_q;
	logic                     neg_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q;
	logic [ROW_W-1:0]         neighbour_index_q;
	logic signed [SCORE_W-1:0] similarity_q;
	logic                     status_q;
	logic                     last_q;

	logic [COL_W-1:0]         dim_m1;
	logic [ROW_W-1:0]         vocab_m1;
	logic [KCNT_W-1:0]        eff_k;
	logic                     in_acc;
	logic                     ld_ok;
	logic                     out_load;
	logic signed [SCORE_W-1:0] sat_score;
	logic signed [ELEM_W-1:0] mult_b;
	logic [ELEM_W-1:0]        mag;
	logic signed [ELEM_W-1:0] norm_val;

	logic                     emb_we;
	logic [ADDR_W-1:0]        emb_waddr;
	logic [ELEM_W-1:0]        emb_wdata;
	logic [ADDR_W-1:0]        emb_raddr;
	logic signed [ELEM_W-1:0] emb_rdata;
	logic                     qv_we;
	logic signed [ELEM_W-1:0] qv_rdata;
	logic                     flag_we;
	logic [ROW_W-1:0]         flag_waddr;
	logic [ROW_W-1:0]         flag_raddr;
	logic                     flag_rdata;

	sd_cmd_t                  sd_cmd;
	logic                     sd_busy;
	logic [QUO_W-1:0]         sd_quo;
	bl_cmd_t                  bl_cmd;
	logic [KCNT_W-1:0]        bl_count;
	logic signed [SCORE_W-1:0] bl_score;
	logic [ROW_W-1:0]         bl_index;

	// effective register values
	always_comb begin
		if (vector_dim_q == '0) begin
			dim_m1 = '0;
		end else if (vector_dim_q > VDIM_W'(DIM_MAX)) begin
			dim_m1 = COL_W'(DIM_MAX - 1);
		end else begin
			dim_m1 = COL_W'(vector_dim_q - VDIM_W'(1));
		end
		if (vocab_count_q == '0) begin
			vocab_m1 = '0;
		end else if (vocab_count_q > VCNT_W'(VOCAB_MAX)) begin
			vocab_m1 = ROW_W'(VOCAB_MAX - 1);
		end else begin
			vocab_m1 = ROW_W'(vocab_count_q - VCNT_W'(1));
		end
		eff_k = (top_k_q > TOPK_W'(K_MAX)) ? KCNT_W'(K_MAX) : KCNT_W'(top_k_q);
	end

	// handshakes
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign ld_ok    = in_acc && (op == OP_LOAD) && !(row_index > vocab_m1) &&
	                  !(column_index > dim_m1);
	assign out_load = !out_valid_q || !out_stall;

	// saturate the dot product to 32 bits
	always_comb begin
		if ((&acc_q[ACC_W-1:SCORE_W-1]) || !(|acc_q[ACC_W-1:SCORE_W-1])) begin
			sat_score = acc_q[SCORE_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			sat_score = {1'b1, {(SCORE_W-1){1'b0}}};
		end else begin
			sat_score = {1'b0, {(SCORE_W-1){1'b1}}};
		end
	end

	// multiplier operand, magnitude and signed quotient
	assign mult_b   = (state_q == ST_Q_DOT_D) ? qv_rdata : emb_rdata;
	assign mag      = emb_rdata[ELEM_W-1] ? ELEM_W'(-emb_rdata) : ELEM_W'(emb_rdata);
	assign norm_val = neg_q ? -$signed(sd_quo) : $signed(sd_quo);

	// table memory ports
	always_comb begin
		emb_we    = ld_ok || (state_q == ST_N_ZERO) || ((state_q == ST_N_DIV_W) && !sd_busy);
		emb_waddr = (state_q == ST_IDLE) ? {row_index, column_index} : {row_q, j_q};
		if (state_q == ST_IDLE) begin
			emb_wdata = element_value;
		end else if (state_q == ST_N_ZERO) begin
			emb_wdata = '0;
		end else begin
			emb_wdata = norm_val;
		end
		case (state_q)
			ST_Q_CPY_A: emb_raddr = {qrow_q, j_q};
			ST_Q_DOT_A: emb_raddr = {r_q, j_q};
			default:    emb_raddr = {row_q, j_q};
		endcase
	end

	// loaded flag ports
	always_comb begin
		flag_we    = (state_q == ST_CLEAR) || (ld_ok && (column_index != dim_m1)) ||
		             (state_q == ST_N_MARK);
		flag_waddr = (state_q == ST_CLEAR) ? r_q :
		             (state_q == ST_IDLE) ? row_index : row_q;
		flag_raddr = (state_q == ST_IDLE) ? query_row : r_q;
	end

	assign qv_we = (state_q == ST_Q_CPY_D);

	// helper unit commands
	assign sd_cmd.start_sqrt = (state_q == ST_N_ROOT) && (acc_q != '0);
	assign sd_cmd.start_div  = (state_q == ST_N_DIV_D);
	assign bl_cmd.clear      = (state_q == ST_Q_FLAG);
	assign bl_cmd.offer      = (state_q == ST_Q_OFFER);

	ctks_ram #(.WIDTH(ELEM_W), .DEPTH(VOCAB_MAX * DIM_MAX)) u_emb_ram (
		.clk   (clk),
		.we    (emb_we),
		.waddr (emb_waddr),
		.wdata (emb_wdata),
		.raddr (emb_raddr),
		.rdata (emb_rdata)
	);

	ctks_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_MAX)) u_qv_ram (
		.clk   (clk),
		.we    (qv_we),
		.waddr (j_q),
		.wdata (emb_rdata),
		.raddr (j_q),
		.rdata (qv_rdata)
	);

	ctks_ram #(.WIDTH(1), .DEPTH(VOCAB_MAX)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (state_q == ST_N_MARK),
		.raddr (flag_raddr),
		.rdata (flag_rdata)
	);

	ctks_sqdiv u_sqdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (sd_cmd),
		.sum      (acc_q[SUM_W-1:0]),
		.mag      (mag),
		.busy     (sd_busy),
		.quotient (sd_quo)
	);

	ctks_best_list u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (bl_cmd),
		.k        (k_q),
		.score    (sat_score),
		.index    (r_q),
		.rd_sel   (e_q),
		.count    (bl_count),
		.rd_score (bl_score),
		.rd_index (bl_index)
	);

	// sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			r_q           <= '0;
			top_k_q       <= TOP_K_RST;
			vector_dim_q  <= VECTOR_DIM_RST;
			vocab_count_q <= VOCAB_COUNT_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TOP_K:       top_k_q       <= cfg_data[TOPK_W-1:0];
					CFG_VECTOR_DIM:  vector_dim_q  <= cfg_data[VDIM_W-1:0];
					CFG_VOCAB_COUNT: vocab_count_q <= cfg_data[VCNT_W-1:0];
					default: ;
				endcase
			end
			// emit states refill the output register themselves
			if (out_valid_q && !out_stall && (state_q != ST_EMIT) &&
			    (state_q != ST_EMIT_NF)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					if (r_q == ROW_W'(VOCAB_MAX - 1)) begin
						state_q <= ST_IDLE;
					end
					r_q <= r_q + ROW_W'(1);
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (op == OP_QUERY) begin
							qrow_q  <= query_row;
							state_q <= (query_row > vocab_m1) ? ST_EMIT_NF : ST_Q_FLAG;
						end else if (ld_ok && (column_index == dim_m1)) begin
							row_q   <= row_index;
							j_q     <= '0;
							acc_q   <= '0;
							state_q <= ST_N_SUM_A;
						end
					end
				end
				// sum of squares over the row
				ST_N_SUM_A: state_q <= ST_N_SUM_D;
				ST_N_SUM_D: begin
					prod_s1 <= emb_rdata * mult_b;
					state_q <= ST_N_SUM_ACC;
				end
				ST_N_SUM_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_s1);
					if (j_q == dim_m1) begin
						state_q <= ST_N_ROOT;
					end else begin
						j_q     <= j_q + COL_W'(1);
						state_q <= ST_N_SUM_A;
					end
				end
				ST_N_ROOT: begin
					j_q     <= '0;
					state_q <= (acc_q == '0) ? ST_N_ZERO : ST_N_ROOT_W;
				end
				ST_N_ROOT_W: begin
					if (!sd_busy) begin
						state_q <= ST_N_DIV_A;
					end
				end
				// zero row stays zero
				ST_N_ZERO: begin
					if (j_q == dim_m1) begin
						state_q <= ST_N_MARK;
					end else begin
						j_q <= j_q + COL_W'(1);
					end
				end
				// scale each element by the row length
				ST_N_DIV_A: state_q <= ST_N_DIV_D;
				ST_N_DIV_D: begin
					neg_q   <= emb_rdata[ELEM_W-1];
					state_q <= ST_N_DIV_W;
				end
				ST_N_DIV_W: begin
					if (!sd_busy) begin
						if (j_q == dim_m1) begin
							state_q <= ST_N_MARK;
						end else begin
							j_q     <= j_q + COL_W'(1);
							state_q <= ST_N_DIV_A;
						end
					end
				end
				ST_N_MARK: state_q <= ST_IDLE;
				// query row lookup
				ST_Q_FLAG: begin
					j_q <= '0;
					k_q <= eff_k;
					if (!flag_rdata) begin
						state_q <= ST_EMIT_NF;
					end else if (eff_k == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_Q_CPY_A;
					end
				end
				ST_Q_CPY_A: state_q <= ST_Q_CPY_D;
				ST_Q_CPY_D: begin
					if (j_q == dim_m1) begin
						r_q     <= '0;
						state_q <= ST_Q_ROW_A;
					end else begin
						j_q     <= j_q + COL_W'(1);
						state_q <= ST_Q_CPY_A;
					end
				end
				// scan the table
				ST_Q_ROW_A: state_q <= ST_Q_ROW_D;
				ST_Q_ROW_D: begin
					j_q   <= '0;
					acc_q <= '0;
					if ((r_q == qrow_q) || !flag_rdata) begin
						state_q <= ST_Q_NEXT;
					end else begin
						state_q <= ST_Q_DOT_A;
					end
				end
				ST_Q_DOT_A: state_q <= ST_Q_DOT_D;
				ST_Q_DOT_D: begin
					prod_s1 <= emb_rdata * mult_b;
					state_q <= ST_Q_DOT_ACC;
				end
				ST_Q_DOT_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_s1);
					if (j_q == dim_m1) begin
						state_q <= ST_Q_OFFER;
					end else begin
						j_q     <= j_q + COL_W'(1);
						state_q <= ST_Q_DOT_A;
					end
				end
				ST_Q_OFFER: state_q <= ST_Q_NEXT;
				ST_Q_NEXT: begin
					if (r_q == vocab_m1) begin
						e_q     <= '0;
						state_q <= (bl_count == '0) ? ST_IDLE : ST_EMIT;
					end else begin
						r_q     <= r_q + ROW_W'(1);
						state_q <= ST_Q_ROW_A;
					end
				end
				// hand out the list
				ST_EMIT: begin
					if (out_load) begin
						out_valid_q       <= 1'b1;
						neighbour_index_q <= bl_index;
						similarity_q      <= bl_score;
						status_q          <= ST_FOUND;
						last_q            <= (KCNT_W'(e_q) + KCNT_W'(1) == bl_count);
						if (KCNT_W'(e_q) + KCNT_W'(1) == bl_count) begin
							state_q <= ST_IDLE;
						end else begin
							e_q <= e_q + KIDX_W'(1);
						end
					end
				end
				ST_EMIT_NF: begin
					if (out_load) begin
						out_valid_q       <= 1'b1;
						neighbour_index_q <= '0;
						similarity_q      <= '0;
						status_q          <= ST_NOT_FOUND;
						last_q            <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign neighbour_index = neighbour_index_q;
	assign similarity      = similarity_q;
	assign status          = status_q;
	assign last            = last_q;

`ifndef ASSERT_OFF
	// a not-found result always closes its query
	a_nf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_FOUND) |-> last)
		else $error("not-found result without last");

	// the sqrt/divide unit only runs while the sequencer waits on it
	a_sd_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sd_busy |-> (state_q == ST_N_ROOT_W) || (state_q == ST_N_DIV_W))
		else $error("sqrt/divide busy outside a wait state");

	// the best list never grows beyond k
	a_bl_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_NEXT) |-> (bl_count <= k_q))
		else $error("best list larger than k");

	// the list is never emitted empty
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (bl_count != '0))
		else $error("emitting an empty best list");
`endif

endmodule
